@@ sv/saes_pkg.sv @@
// Shared types, constants and functions for the 16-bit simplified AES block.
// Holds the nibble S-boxes, GF(16) arithmetic, round steps and key expansion.
// No dependencies.
package saes_pkg;

   localparam int BLOCK_W = 16;
   localparam int KEY_W   = 16;

   localparam logic [6:0] GF_POLY  = 7'h13;
   localparam logic [7:0] RCON_ONE = 8'h80;
   localparam logic [7:0] RCON_TWO = 8'h30;

   // mix column coefficients, forward and inverse
   localparam logic [3:0] MIX_FWD_D = 4'd1;
   localparam logic [3:0] MIX_FWD_O = 4'd4;
   localparam logic [3:0] MIX_INV_D = 4'd9;
   localparam logic [3:0] MIX_INV_O = 4'd2;

   typedef enum logic {
      DIR_ENCRYPT = 1'b0,
      DIR_DECRYPT = 1'b1
   } dir_type;

   typedef struct packed {
      logic [BLOCK_W-1:0] rk0;
      logic [BLOCK_W-1:0] rk1;
      logic [BLOCK_W-1:0] rk2;
   } round_keys_type;

   typedef struct packed {
      logic s1_valid;
      logic s2_valid;
      logic s3_valid;
      logic s1_advance;
   } pipe_status_type;

   function automatic logic [3:0] sbox_fwd(input logic [3:0] n);
      logic [3:0] r;
      case (n)
         4'h0: r = 4'd9;   4'h1: r = 4'd4;   4'h2: r = 4'd10;  4'h3: r = 4'd11;
         4'h4: r = 4'd13;  4'h5: r = 4'd1;   4'h6: r = 4'd8;   4'h7: r = 4'd5;
         4'h8: r = 4'd6;   4'h9: r = 4'd2;   4'hA: r = 4'd0;   4'hB: r = 4'd3;
         4'hC: r = 4'd12;  4'hD: r = 4'd14;  4'hE: r = 4'd15;  default: r = 4'd7;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] sbox_inv(input logic [3:0] n);
      logic [3:0] r;
      case (n)
         4'h0: r = 4'd10;  4'h1: r = 4'd5;   4'h2: r = 4'd9;   4'h3: r = 4'd11;
         4'h4: r = 4'd1;   4'h5: r = 4'd7;   4'h6: r = 4'd8;   4'h7: r = 4'd15;
         4'h8: r = 4'd6;   4'h9: r = 4'd0;   4'hA: r = 4'd2;   4'hB: r = 4'd3;
         4'hC: r = 4'd12;  4'hD: r = 4'd4;   4'hE: r = 4'd13;  default: r = 4'd14;
      endcase
      return r;
   endfunction

   function automatic logic [BLOCK_W-1:0] sub_word(input logic [BLOCK_W-1:0] w,
                                                   input logic inv);
      logic [BLOCK_W-1:0] r;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         r[4*i +: 4] = inv ? sbox_inv(w[4*i +: 4]) : sbox_fwd(w[4*i +: 4]);
      end
      return r;
   endfunction

   // swap the second and fourth nibble
   function automatic logic [BLOCK_W-1:0] nibble_swap(input logic [BLOCK_W-1:0] w);
      return {w[15:12], w[3:0], w[7:4], w[11:8]};
   endfunction

   function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
      logic [6:0] acc;
      acc = '0;
      for (int i = 0; i < 4; i++) begin
         if (a[i]) begin
            acc = acc ^ ({3'b000, b} << i);
         end
      end
      for (int i = 6; i >= 4; i--) begin
         if (acc[i]) begin
            acc = acc ^ (GF_POLY << (i - 4));
         end
      end
      return acc[3:0];
   endfunction

   function automatic logic [BLOCK_W-1:0] mix_col(input logic [BLOCK_W-1:0] w,
                                                  input logic [3:0] d,
                                                  input logic [3:0] o);
      logic [3:0] m0, m1, m2, m3;
      m0 = gf_mul(d, w[15:12]) ^ gf_mul(o, w[11:8]);
      m1 = gf_mul(o, w[15:12]) ^ gf_mul(d, w[11:8]);
      m2 = gf_mul(d, w[7:4])   ^ gf_mul(o, w[3:0]);
      m3 = gf_mul(o, w[7:4])   ^ gf_mul(d, w[3:0]);
      return {m0, m1, m2, m3};
   endfunction

   function automatic logic [7:0] rot_sub(input logic [7:0] b);
      return {sbox_fwd(b[3:0]), sbox_fwd(b[7:4])};
   endfunction

   function automatic round_keys_type expand_key(input logic [KEY_W-1:0] key);
      logic [7:0] w0, w1, w2, w3, w4, w5;
      round_keys_type rk;
      w0 = key[15:8];
      w1 = key[7:0];
      w2 = w0 ^ RCON_ONE ^ rot_sub(w1);
      w3 = w2 ^ w1;
      w4 = w2 ^ RCON_TWO ^ rot_sub(w3);
      w5 = w4 ^ w3;
      rk.rk0 = {w0, w1};
      rk.rk1 = {w2, w3};
      rk.rk2 = {w4, w5};
      return rk;
   endfunction

endpackage

@@ sv/saes_key_sched.sv @@
// Key schedule: expands a written cipher key into three registered round keys.
// Depends on saes_pkg.
module saes_key_sched import saes_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [KEY_W-1:0]     csr_wdata,
   output round_keys_type       round_keys
);

   round_keys_type rk_ff, rk_in;

   always_comb begin
      rk_in = rk_ff;
      if (csr_we) begin
         rk_in = expand_key(csr_wdata);
      end
   end

   // reset key is all zeros
   always_ff @(posedge clock) begin
      if (reset) begin
         rk_ff <= expand_key('0);
      end else begin
         rk_ff <= rk_in;
      end
   end

   assign round_keys = rk_ff;

endmodule

@@ sv/saes_datapath.sv @@
// Three-stage cipher pipeline with per-stage valid bits and backpressure.
// Depends on saes_pkg; round keys come from saes_key_sched.
module saes_datapath import saes_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  round_keys_type       round_keys,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic                 in_dir,
   input  logic [BLOCK_W-1:0]   in_block,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [BLOCK_W-1:0]   out_block,
   output pipe_status_type      status
);

   logic               v1_ff, v2_ff, v3_ff;
   logic               v1_in, v2_in, v3_in;
   dir_type            dir1_ff, dir2_ff;
   logic [BLOCK_W-1:0] s1_ff, s2_ff, s3_ff;
   logic [BLOCK_W-1:0] s1_in, s2_in, s3_in;
   dir_type            dir0;
   logic               adv1, adv2, adv3;

   // a stage moves when it is empty or its successor takes its word
   assign adv3 = !v3_ff || out_ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign dir0 = dir_type'(in_dir);

   // stage 1: first key add and substitution, with a shift row before the substitution when decrypting
   always_comb begin
      if (dir0 == DIR_ENCRYPT) begin
         s1_in = sub_word(in_block ^ round_keys.rk0, 1'b0);
      end else begin
         s1_in = sub_word(nibble_swap(in_block ^ round_keys.rk2), 1'b1);
      end
   end

   // stage 2: mix column and middle key add, with a shift row before the mix when encrypting
   always_comb begin
      if (dir1_ff == DIR_ENCRYPT) begin
         s2_in = mix_col(nibble_swap(s1_ff), MIX_FWD_D, MIX_FWD_O) ^ round_keys.rk1;
      end else begin
         s2_in = mix_col(s1_ff ^ round_keys.rk1, MIX_INV_D, MIX_INV_O);
      end
   end

   // stage 3: last substitution, shift row and key add
   always_comb begin
      if (dir2_ff == DIR_ENCRYPT) begin
         s3_in = nibble_swap(sub_word(s2_ff, 1'b0)) ^ round_keys.rk2;
      end else begin
         s3_in = sub_word(nibble_swap(s2_ff), 1'b1) ^ round_keys.rk0;
      end
   end

   assign v1_in = adv1 ? in_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff    : v2_ff;
   assign v3_in = adv3 ? v2_ff    : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff   <= s1_in;
         dir1_ff <= dir0;
      end
      if (adv2) begin
         s2_ff   <= s2_in;
         dir2_ff <= dir1_ff;
      end
      if (adv3) begin
         s3_ff <= s3_in;
      end
   end

   assign in_ready  = adv1;
   assign out_valid = v3_ff;
   assign out_block = s3_ff;

   assign status.s1_valid   = v1_ff;
   assign status.s2_valid   = v2_ff;
   assign status.s3_valid   = v3_ff;
   assign status.s1_advance = adv1;

endmodule

@@ sv/saes_block_cipher.sv @@
// Simplified AES on 16-bit blocks. Each request word carries one block and a
// direction flag (tuser: 0 encrypt, 1 decrypt); each response word carries the
// result block. The pipeline has three register stages, and the response
// word comes from the last of them. One block is accepted every cycle while
// the response side keeps taking words. The round keys are expanded
// and registered when csr_we is high, so a new key applies to blocks accepted
// from the next cycle on; blocks still in the pipeline would see a mix of old
// and new round keys, so write the key only while the pipeline is empty.
// Reset loads the round keys of the all-zero key.
module saes_block_cipher import saes_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [15:0]   csr_wdata,     // cipher_key
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [15:0]   req_tdata,     // [15:0] block_in
   input  logic          req_tuser,     // [0] req_type
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [15:0]   rsp_tdata      // [15:0] block_out
);

   round_keys_type  round_keys;
   pipe_status_type status;

   saes_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .round_keys (round_keys)
   );

   saes_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .round_keys (round_keys),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_dir     (req_tuser),
      .in_block   (req_tdata),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_block  (rsp_tdata),
      .status     (status)
   );

   // full pipeline with a stalled output must refuse new words
   assert property (@(posedge clock) disable iff (reset)
      status.s1_valid && status.s2_valid && status.s3_valid && !rsp_tready
      |-> !req_tready)
      else $error("request taken while pipeline is full and stalled");

   // an accepted word occupies the first stage next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> status.s1_valid)
      else $error("accepted word lost at stage one");

   // a key write loads the first round key with the key itself
   assert property (@(posedge clock) disable iff (reset)
      csr_we |=> round_keys.rk0 == $past(csr_wdata))
      else $error("round key zero does not match written key");

   // a waiting result stays in the output stage
   assert property (@(posedge clock) disable iff (reset)
      status.s3_valid && !rsp_tready |=> status.s3_valid)
      else $error("output word dropped while stalled");

endmodule

@@ bench/saes_block_cipher_test.sv @@
// Self-checking bench for saes_block_cipher: a directed table, then random and
// round-trip blocks under several keys, checked against an in-bench cipher model.
// Depends on saes_pkg and the saes_block_cipher RTL.
`timescale 1ns / 100ps

module saes_block_cipher_test;
   import saes_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BLOCKS = 184;
   localparam int HOLD_CYCLES = 60;
   localparam int DRAIN_CYCLES = 10;

   // nibble tables, entry 0 in the lowest four bits
   localparam logic [63:0] SUB_FWD = 64'h7FEC_3026_581D_BA49;
   localparam logic [63:0] SUB_INV = 64'hED4C_3206_F871_B95A;
   localparam logic [7:0] REDUCE_POLY = 8'h13;
   localparam logic [7:0] RCON_A = 8'h80;
   localparam logic [7:0] RCON_B = 8'h30;

   typedef struct {
      logic set_key;
      logic [15:0] key;
      dir_type dir;
      logic [15:0] blk;
      logic known;
      logic [15:0] result;
   } vector_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [15:0] csr_wdata = 16'h0000;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = 16'h0000;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   logic [15:0] key_shadow = 16'h0000;
   logic [15:0] expected_blocks[$];
   vector_row_type vectors[$];
   int error_count = 0;
   int cycle_count = 0;
   int src_idle_pct = 0;
   int sink_idle_pct = 0;
   bit hold_request = 1'b0;
   logic [15:0] last_result = 16'h0000;
   dir_type last_dir = DIR_ENCRYPT;

   saes_block_cipher dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("saes_block_cipher_test: done, errors");
      $finish;
   end

   function automatic logic [15:0] nib_sub(input logic [15:0] w, input logic [63:0] tab);
      logic [15:0] r;
      for (int i = 0; i < 4; i++) begin
         r[4*i +: 4] = tab[{w[4*i +: 4], 2'b00} +: 4];
      end
      return r;
   endfunction

   function automatic logic [15:0] row_swap(input logic [15:0] w);
      return {w[15:12], w[3:0], w[7:4], w[11:8]};
   endfunction

   function automatic logic [3:0] gf_times(input logic [3:0] a, input logic [3:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 4; i++) begin
         if (a[i]) acc = acc ^ ({4'h0, b} << i);
      end
      for (int i = 7; i >= 4; i--) begin
         if (acc[i]) acc = acc ^ (REDUCE_POLY << (i - 4));
      end
      return acc[3:0];
   endfunction

   function automatic logic [15:0] col_mix(input logic [15:0] w, input logic [3:0] d,
                                           input logic [3:0] o);
      return {gf_times(d, w[15:12]) ^ gf_times(o, w[11:8]),
              gf_times(o, w[15:12]) ^ gf_times(d, w[11:8]),
              gf_times(d, w[7:4]) ^ gf_times(o, w[3:0]),
              gf_times(o, w[7:4]) ^ gf_times(d, w[3:0])};
   endfunction

   // three round keys packed {rk0, rk1, rk2}
   function automatic logic [47:0] round_keys_of(input logic [15:0] k);
      logic [7:0] w2, w3, w4, w5;
      logic [15:0] t;
      t = nib_sub({8'h00, k[3:0], k[7:4]}, SUB_FWD);
      w2 = k[15:8] ^ RCON_A ^ t[7:0];
      w3 = w2 ^ k[7:0];
      t = nib_sub({8'h00, w3[3:0], w3[7:4]}, SUB_FWD);
      w4 = w2 ^ RCON_B ^ t[7:0];
      w5 = w4 ^ w3;
      return {k, w2, w3, w4, w5};
   endfunction

   function automatic logic [15:0] cipher_out(input dir_type dir, input logic [15:0] blk);
      logic [47:0] rk;
      logic [15:0] s;
      rk = round_keys_of(key_shadow);
      s = blk;
      if (dir == DIR_ENCRYPT) begin
         s = s ^ rk[47:32];
         s = col_mix(row_swap(nib_sub(s, SUB_FWD)), MIX_FWD_D, MIX_FWD_O) ^ rk[31:16];
         s = row_swap(nib_sub(s, SUB_FWD)) ^ rk[15:0];
      end else begin
         s = s ^ rk[15:0];
         s = nib_sub(row_swap(s), SUB_INV) ^ rk[31:16];
         s = col_mix(s, MIX_INV_D, MIX_INV_O);
         s = nib_sub(row_swap(s), SUB_INV) ^ rk[47:32];
      end
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t: %s: got %h, want %h", $time, what, got, want);
      error_count++;
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_blocks.size() == 0) begin
            report_mismatch("unexpected result word", rsp_tdata, 16'hxxxx);
         end else begin
            if (rsp_tdata !== expected_blocks[0]) begin
               report_mismatch("block_out", rsp_tdata, expected_blocks[0]);
            end
            void'(expected_blocks.pop_front());
         end
      end
   end

   task automatic send_block(input dir_type dir, input logic [15:0] blk, input logic known,
                             input logic [15:0] typed);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= 16'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= dir;
      req_tdata <= blk;
      do @(posedge clock); while (!req_tready);
      last_result = known ? typed : cipher_out(dir, blk);
      last_dir = dir;
      expected_blocks.push_back(last_result);
   endtask

   // drain the pipe, then load a new key
   task automatic load_key(input logic [15:0] k);
      req_tvalid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= k;
      @(posedge clock);
      csr_we <= 1'b0;
      key_shadow = k;
   endtask

   initial begin
      logic [15:0] blk;
      dir_type dir;

      // after reset the key is all zeros
      vectors.push_back('{1'b0, 16'h0000, DIR_ENCRYPT, 16'h0000, 1'b0, 16'h0000});
      vectors.push_back('{1'b0, 16'h0000, DIR_ENCRYPT, 16'hFFFF, 1'b0, 16'h0000});
      vectors.push_back('{1'b0, 16'h0000, DIR_DECRYPT, 16'h0000, 1'b0, 16'h0000});
      vectors.push_back('{1'b0, 16'h0000, DIR_DECRYPT, 16'hFFFF, 1'b0, 16'h0000});
      vectors.push_back('{1'b1, 16'hFFFF, DIR_ENCRYPT, 16'h0000, 1'b0, 16'h0000});
      vectors.push_back('{1'b0, 16'h0000, DIR_ENCRYPT, 16'hFFFF, 1'b0, 16'h0000});
      vectors.push_back('{1'b0, 16'h0000, DIR_DECRYPT, 16'h0000, 1'b0, 16'h0000});
      vectors.push_back('{1'b0, 16'h0000, DIR_DECRYPT, 16'hFFFF, 1'b0, 16'h0000});
      // textbook vector, both directions
      vectors.push_back('{1'b1, 16'h4AF5, DIR_ENCRYPT, 16'hD728, 1'b1, 16'h24EC});
      vectors.push_back('{1'b0, 16'h0000, DIR_DECRYPT, 16'h24EC, 1'b1, 16'hD728});
      vectors.push_back('{1'b0, 16'h0000, DIR_ENCRYPT, 16'h8000, 1'b0, 16'h0000});
      vectors.push_back('{1'b0, 16'h0000, DIR_DECRYPT, 16'h0001, 1'b0, 16'h0000});
      vectors.push_back('{1'b0, 16'h0000, DIR_ENCRYPT, 16'h5A5A, 1'b0, 16'h0000});
      vectors.push_back('{1'b0, 16'h0000, DIR_DECRYPT, 16'hA5A5, 1'b0, 16'h0000});
      vectors.push_back('{1'b1, 16'h8000, DIR_ENCRYPT, 16'h0001, 1'b0, 16'h0000});
      vectors.push_back('{1'b0, 16'h0000, DIR_DECRYPT, 16'h8000, 1'b0, 16'h0000});
      vectors.push_back('{1'b1, 16'h0001, DIR_ENCRYPT, 16'h8000, 1'b0, 16'h0000});
      vectors.push_back('{1'b0, 16'h0000, DIR_DECRYPT, 16'hFFFF, 1'b0, 16'h0000});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vectors[i]) begin
         if (vectors[i].set_key) load_key(vectors[i].key);
         send_block(vectors[i].dir, vectors[i].blk, vectors[i].known, vectors[i].result);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               load_key(16'($urandom));
               src_idle_pct = 17;
               sink_idle_pct = 63;
            end
            1: begin
               load_key(16'($urandom));
               src_idle_pct = 63;
               sink_idle_pct = 17;
            end
            default: begin
               load_key(16'h0000);
               src_idle_pct = 0;
               sink_idle_pct = 0;
               // back up the pipe while blocks keep coming
               hold_request = 1'b1;
            end
         endcase
         for (int n = 0; n < PHASE_BLOCKS; n++) begin
            // most words run the previous result back through the opposite direction
            if ($urandom_range(3) != 0 && n > 0) begin
               dir = (last_dir == DIR_ENCRYPT) ? DIR_DECRYPT : DIR_ENCRYPT;
               blk = last_result;
            end else begin
               dir = dir_type'($urandom_range(1));
               blk = 16'($urandom);
            end
            send_block(dir, blk, 1'b0, 16'h0000);
         end
      end

      req_tvalid <= 1'b0;
      sink_idle_pct = 0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("saes_block_cipher_test: done, clean");
      end else begin
         $display("saes_block_cipher_test: done, errors");
      end
      $finish;
   end

endmodule
